>>> rtl/core/scld_pkg.sv
package scld_pkg;

    // default line capacity, one position is held back so at most capacity-1 bytes are kept
    localparam int LINE_CAPACITY_DEF = 32;

    // command kinds
    localparam logic [1:0] KIND_READ    = 2'd0;
    localparam logic [1:0] KIND_DAC     = 2'd1;
    localparam logic [1:0] KIND_INVALID = 2'd2;

    // display glyphs
    localparam logic [1:0] GLYPH_NONE = 2'd0;
    localparam logic [1:0] GLYPH_L    = 2'd1;
    localparam logic [1:0] GLYPH_T    = 2'd2;
    localparam logic [1:0] GLYPH_V    = 2'd3;

    // line end and special characters
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] SIGN_POS   = 8'h2B;
    localparam logic [7:0] SIGN_NEG   = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // command words, first character in the top byte
    localparam logic [71:0] WORD_AIN0 = {"Read_AIN", "0"};
    localparam logic [71:0] WORD_AIN1 = {"Read_AIN", "1"};
    localparam logic [71:0] WORD_AIN3 = {"Read_AIN", "3"};
    localparam logic [63:0] WORD_DAC  = {"Set_DAC", "_"};
    localparam int          READ_LEN  = 9;
    localparam int          DAC_LEN   = 8;

    // converter control bytes
    localparam logic [7:0] CTRL_DAC       = 8'h40;
    localparam logic [7:0] CTRL_CHAN_MASK = 8'h03;
    localparam logic [8:0] DAC_MAX        = 9'd255;
    localparam logic [8:0] DAC_SAT        = 9'd256;

    // number parser phases
    localparam logic [1:0] NUM_SKIP = 2'd0;
    localparam logic [1:0] NUM_IN   = 2'd1;
    localparam logic [1:0] NUM_DONE = 2'd2;

    typedef struct packed {
        logic [7:0] bus_control_byte;
        logic [7:0] dac_value;
        logic [1:0] glyph_letter;
        logic [1:0] analog_channel;
        logic [1:0] command_kind;
    } scld_result_t;

    localparam int RESULT_W = $bits(scld_result_t);
    localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

    // character of a read word at a position below READ_LEN
    function automatic logic [7:0] read_char(input logic [71:0] w, input logic [3:0] pos);
        return w[8 * (READ_LEN - 1 - int'(pos)) +: 8];
    endfunction

    // character of the dac prefix at a position below DAC_LEN
    function automatic logic [7:0] dac_char(input logic [3:0] pos);
        return WORD_DAC[8 * (DAC_LEN - 1 - int'(pos)) +: 8];
    endfunction

endpackage

>>> rtl/core/scld_line_decoder.sv
module scld_line_decoder import scld_pkg::*; #(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         step_en,
    input  logic [7:0]   rx_byte,
    output logic         result_valid,
    output scld_result_t result
);

    localparam int             CW       = $clog2(LINE_CAPACITY);
    localparam logic [CW-1:0]  LAST_POS = CW'(LINE_CAPACITY - 1);
    localparam logic [CW-1:0]  POS_READ = CW'(READ_LEN);
    localparam logic [CW-1:0]  POS_DAC  = CW'(DAC_LEN);

    logic [CW-1:0] count_reg, count_next;
    logic [2:0]    exact_reg, exact_next;
    logic          prefix_reg, prefix_next;
    logic [1:0]    phase_reg, phase_next;
    logic          neg_reg, neg_next;
    logic [8:0]    value_reg, value_next;
    logic          ended_reg, ended_next;

    logic          is_eol;
    logic          is_digit;
    logic          is_blank;
    logic [3:0]    pos;
    logic [11:0]   acc;

    assign is_eol   = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF);
    assign is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
    assign is_blank = (rx_byte == CHAR_SPACE) || ((rx_byte >= CHAR_TAB) && (rx_byte <= CHAR_CR));
    assign pos      = count_reg[3:0];
    assign acc      = {3'b000, value_reg} * 12'd10 + {8'h00, rx_byte[3:0]};

    // incremental matching and line end handling
    always_comb begin
        count_next   = count_reg;
        exact_next   = exact_reg;
        prefix_next  = prefix_reg;
        phase_next   = phase_reg;
        neg_next     = neg_reg;
        value_next   = value_reg;
        ended_next   = ended_reg;
        result_valid = 1'b0;
        if (!is_eol) begin
            if (count_reg < LAST_POS) begin
                count_next = count_reg + CW'(1);
                if (!ended_reg) begin
                    // exact read words
                    if (count_reg < POS_READ) begin
                        if (rx_byte != read_char(WORD_AIN0, pos)) exact_next[0] = 1'b0;
                        if (rx_byte != read_char(WORD_AIN1, pos)) exact_next[1] = 1'b0;
                        if (rx_byte != read_char(WORD_AIN3, pos)) exact_next[2] = 1'b0;
                    end else if (rx_byte != CHAR_NUL) begin
                        exact_next = 3'b000;
                    end
                    // dac prefix, then the decimal number
                    if (count_reg < POS_DAC) begin
                        if (rx_byte != dac_char(pos)) prefix_next = 1'b0;
                    end else if (rx_byte != CHAR_NUL) begin
                        case (phase_reg)
                            NUM_SKIP: begin
                                if (is_blank) begin
                                    phase_next = NUM_SKIP;
                                end else if ((rx_byte == SIGN_POS) || (rx_byte == SIGN_NEG)) begin
                                    neg_next   = (rx_byte == SIGN_NEG);
                                    phase_next = NUM_IN;
                                end else if (is_digit) begin
                                    value_next = {5'b00000, rx_byte[3:0]};
                                    phase_next = NUM_IN;
                                end else begin
                                    phase_next = NUM_DONE;
                                end
                            end
                            NUM_IN: begin
                                if (is_digit) begin
                                    value_next = (acc > 12'(DAC_MAX)) ? DAC_SAT : acc[8:0];
                                end else begin
                                    phase_next = NUM_DONE;
                                end
                            end
                            default: begin
                                phase_next = phase_reg;
                            end
                        endcase
                    end
                    if (rx_byte == CHAR_NUL) ended_next = 1'b1;
                end
            end
        end else if (count_reg != '0) begin
            result_valid = 1'b1;
            count_next   = '0;
            exact_next   = 3'b111;
            prefix_next  = 1'b1;
            phase_next   = NUM_SKIP;
            neg_next     = 1'b0;
            value_next   = '0;
            ended_next   = 1'b0;
        end
    end

    // decode of the finished line
    always_comb begin
        result = '0;
        result.command_kind = KIND_INVALID;
        if ((count_reg >= POS_READ) && exact_reg[1]) begin
            result.command_kind   = KIND_READ;
            result.analog_channel = 2'd1;
            result.glyph_letter   = GLYPH_T;
        end else if ((count_reg >= POS_READ) && exact_reg[2]) begin
            result.command_kind   = KIND_READ;
            result.analog_channel = 2'd3;
            result.glyph_letter   = GLYPH_V;
        end else if ((count_reg >= POS_READ) && exact_reg[0]) begin
            result.command_kind   = KIND_READ;
            result.analog_channel = 2'd0;
            result.glyph_letter   = GLYPH_L;
        end else if ((count_reg >= POS_DAC) && prefix_reg) begin
            result.command_kind     = KIND_DAC;
            result.dac_value        = neg_reg ? 8'h00 :
                                      ((value_reg > DAC_MAX) ? DAC_MAX[7:0] : value_reg[7:0]);
            result.bus_control_byte = CTRL_DAC;
        end
        if (result.command_kind == KIND_READ) begin
            result.bus_control_byte = {6'b000000, result.analog_channel} & CTRL_CHAN_MASK;
        end
    end

    // line state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            exact_reg  <= 3'b111;
            prefix_reg <= 1'b1;
            phase_reg  <= NUM_SKIP;
            neg_reg    <= 1'b0;
            value_reg  <= '0;
            ended_reg  <= 1'b0;
        end else if (step_en) begin
            count_reg  <= count_next;
            exact_reg  <= exact_next;
            prefix_reg <= prefix_next;
            phase_reg  <= phase_next;
            neg_reg    <= neg_next;
            value_reg  <= value_next;
            ended_reg  <= ended_next;
        end
    end

endmodule

>>> rtl/core/serial_command_line_decoder_top.sv
// a command line result is registered in the output stage once its CR or LF byte leaves the input register
// throughput: one received byte per cycle; only the line end of a non-empty line waits while a result is held
// a line gives one result at its end, bytes inside a line give none
// reset: synchronous active-low aresetn clears both stages and returns the line to empty
module serial_command_line_decoder_top import scld_pkg::*; #(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // rx_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    // command_kind, analog_channel, glyph_letter, dac_value, bus_control_byte, zero fill
    output logic [TDATA_W-1:0] m_tdata
);

    logic         in_valid_reg, in_valid_next;
    logic [7:0]   in_byte_reg;
    logic         out_valid_reg, out_valid_next;
    scld_result_t out_reg;
    logic         advance;
    logic         res_valid;
    scld_result_t res;

    // input stage moves on unless its line end would overwrite a waiting result
    assign advance  = in_valid_reg && (!res_valid || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    scld_line_decoder #(
        .LINE_CAPACITY(LINE_CAPACITY)
    ) u_decoder (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (advance),
        .rx_byte      (in_byte_reg),
        .result_valid (res_valid),
        .result       (res)
    );

    // handshake control
    always_comb begin
        in_valid_next = s_tready ? s_tvalid : in_valid_reg;
        if (advance && res_valid) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (advance && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'(out_reg);

endmodule

>>> rtl/core/scld_checker.sv
module scld_checker import scld_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic [7:0]         s_tdata,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata
);

    scld_result_t r;
    assign r = scld_result_t'(m_tdata[RESULT_W-1:0]);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a waiting input transaction holds its byte
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("input changed while waiting");

    // no result straight out of reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a read carries its channel in the control byte and the matching glyph
    a_read: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (r.command_kind == KIND_READ) |->
            (r.dac_value == 8'h00) && (r.bus_control_byte == {6'b000000, r.analog_channel})
            && (r.analog_channel != 2'd2)
            && ((r.analog_channel == 2'd0) ? (r.glyph_letter == GLYPH_L) :
                (r.analog_channel == 2'd1) ? (r.glyph_letter == GLYPH_T) :
                                             (r.glyph_letter == GLYPH_V)))
        else $error("inconsistent read result");

    // dac sets and invalid lines carry no channel or glyph
    a_other: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (r.command_kind != KIND_READ) |->
            (r.analog_channel == 2'd0) && (r.glyph_letter == GLYPH_NONE)
            && (((r.command_kind == KIND_DAC) && (r.bus_control_byte == CTRL_DAC))
                || ((r.command_kind == KIND_INVALID) && (r.bus_control_byte == 8'h00)
                    && (r.dac_value == 8'h00))))
        else $error("inconsistent dac or invalid result");

endmodule

bind serial_command_line_decoder_top scld_checker u_scld_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
